/* rtl/pbe_pkg.sv */
`timescale 1ns / 1ps
// Package for the PCI bus enumerator: sizes, phase and result codes,
// register offsets and the result record. No dependencies.
package pbe_pkg;

  localparam int STACK_DEPTH    = 256;
  localparam int DEVS_PER_BUS   = 32;
  localparam int FUNCS_PER_DEV  = 8;
  localparam int STK_AW         = $clog2(STACK_DEPTH);
  localparam int STK_CW         = STK_AW + 1;

  // Result queue: room for two results per transaction plus drain slack.
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  localparam logic [4:0]  OFF_ID      = 5'd0;
  localparam logic [4:0]  OFF_HDR     = 5'd12;
  localparam logic [4:0]  OFF_BUS     = 5'h18;
  localparam logic [15:0] VENDOR_NONE = 16'hffff;
  localparam logic [6:0]  HDR_MASK    = 7'h7f;
  localparam logic [6:0]  HDR_BRIDGE  = 7'h01;

  typedef enum logic {
    IN_START = 1'b0,
    IN_RESP  = 1'b1
  } in_kind_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_ID   = 2'd1,
    PH_HDR  = 2'd2,
    PH_BUS  = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    RK_REQ   = 2'd0,
    RK_FOUND = 2'd1,
    RK_DONE  = 2'd2
  } res_kind_t;

  typedef struct packed {
    res_kind_t   result_kind;
    logic [7:0]  bus_number;
    logic [4:0]  device_number;
    logic [2:0]  function_number;
    logic [4:0]  register_offset;
    logic [31:0] id_word;
    logic        stack_overflowed;
    logic        last;
  } result_t;

endpackage

/* rtl/pbe_ram.sv */
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pbe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/pci_bus_enumerator.sv */
`timescale 1ns / 1ps
// PCI bus enumerator top level. Uses pbe_pkg and pbe_ram (bus stack).
// Timing: an accepted transaction sits in the input register and is processed
//   into the result queue once the queue has room for two results; out_valid is
//   registered, taken from the result queue count.
// Throughput: one input transaction per cycle while the result queue has room,
//   set by the result queue drain (one result per cycle).
// Reset: synchronous active-low rst_n clears phase, scan position, stack count,
//   overflow flag and queues; stack RAM contents are not cleared (no sweep).
module pci_bus_enumerator (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_kind,
  input  logic [31:0] in_read_data,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_result_kind,
  output logic [7:0]  out_bus_number,
  output logic [4:0]  out_device_number,
  output logic [2:0]  out_function_number,
  output logic [4:0]  out_register_offset,
  output logic [31:0] out_id_word,
  output logic        out_stack_overflowed,
  output logic        out_last
);

  localparam int AW = pbe_pkg::STK_AW;
  localparam int CW = pbe_pkg::STK_CW;

  // ---------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------
  logic        inr_valid_r, inr_valid_nxt;
  logic        inr_kind_r;
  logic [31:0] inr_data_r;
  logic        fire;     // held transaction is processed this cycle

  // ---------------------------------------------------------------------
  // Scan state
  // ---------------------------------------------------------------------
  pbe_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]      bus_r, bus_nxt;
  logic [4:0]      dev_r, dev_nxt;
  logic [2:0]      fn_r, fn_nxt;
  logic [31:0]     saved_id_r, saved_id_nxt;
  logic [CW-1:0]   stk_cnt_r, stk_cnt_nxt;
  logic            ovf_r, ovf_nxt;

  // Stack RAM and bypass of a value written at the current read address
  logic            ram_we;
  logic [AW-1:0]   ram_raddr;
  logic [7:0]      ram_rdata;
  logic            byp_r;
  logic [7:0]      byp_data_r;
  logic [7:0]      top_val;

  // Decode
  logic       start_go, rsp;
  logic       id_absent, hdr_bridge;
  logic       adv_en, adv_skip, fn_wrap, dev_wrap;
  logic       push_en, ovf_set, stk_nonempty, stk_pop, scan_done;
  logic [7:0] push_val, pop_val;

  // Results
  pbe_pkg::result_t r0, r1;
  logic [1:0]       n_res;

  // Result queue
  pbe_pkg::result_t          q_mem_r [pbe_pkg::QDEPTH];
  logic [pbe_pkg::QAW-1:0]   q_head_r, q_tail_r, q_tail1;
  logic [pbe_pkg::QCW-1:0]   q_cnt_r;
  logic                      q_pop;

  // Processing needs room for two results; uses the registered count only.
  assign fire     = inr_valid_r && (q_cnt_r <= pbe_pkg::QCW'(pbe_pkg::QDEPTH - 2));
  assign in_ready = !inr_valid_r || fire;

  always_comb begin
    inr_valid_nxt = inr_valid_r;
    if (in_valid && in_ready) begin
      inr_valid_nxt = 1'b1;
    end else if (fire) begin
      inr_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inr_valid_r <= 1'b0;
    end else begin
      inr_valid_r <= inr_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      inr_kind_r <= in_kind;
      inr_data_r <= in_read_data;
    end
  end

  // ---------------------------------------------------------------------
  // Decode of the held transaction
  // ---------------------------------------------------------------------
  assign top_val = byp_r ? byp_data_r : ram_rdata;

  always_comb begin
    start_go   = fire && (inr_kind_r == pbe_pkg::IN_START) && (phase_r == pbe_pkg::PH_IDLE);
    rsp        = fire && (inr_kind_r == pbe_pkg::IN_RESP) && (phase_r != pbe_pkg::PH_IDLE);
    id_absent  = (inr_data_r[15:0] == pbe_pkg::VENDOR_NONE);
    hdr_bridge = ((inr_data_r[22:16] & pbe_pkg::HDR_MASK) == pbe_pkg::HDR_BRIDGE);

    // Advance to the next function after an absent ID, a plain header or a
    // bridge's bus-number read.
    adv_en = rsp && (((phase_r == pbe_pkg::PH_ID) && id_absent) ||
                     ((phase_r == pbe_pkg::PH_HDR) && !hdr_bridge) ||
                     (phase_r == pbe_pkg::PH_BUS));
    // Absent function 0 skips the rest of the device.
    adv_skip = (phase_r == pbe_pkg::PH_ID) && (fn_r == 3'd0);
    fn_wrap  = adv_skip ||
               ((4'(fn_r) + 4'd1) >= 4'(pbe_pkg::FUNCS_PER_DEV));
    dev_wrap = fn_wrap &&
               ((6'(dev_r) + 6'd1) >= 6'(pbe_pkg::DEVS_PER_BUS));

    push_val = inr_data_r[15:8];
    push_en  = rsp && (phase_r == pbe_pkg::PH_BUS) &&
               (stk_cnt_r < CW'(pbe_pkg::STACK_DEPTH));
    ovf_set  = rsp && (phase_r == pbe_pkg::PH_BUS) && !push_en;

    // A bus pushed in this same step counts as stacked; a pop in that step takes it straight back.
    stk_nonempty = (stk_cnt_r != '0) || push_en;
    stk_pop      = adv_en && dev_wrap && stk_nonempty;
    scan_done    = adv_en && dev_wrap && !stk_nonempty;
    pop_val      = push_en ? push_val : top_val;

    ram_we = push_en && !stk_pop;

    if (start_go) begin
      stk_cnt_nxt = '0;
    end else if (ram_we) begin
      stk_cnt_nxt = stk_cnt_r + CW'(1);
    end else if (stk_pop && !push_en) begin
      stk_cnt_nxt = stk_cnt_r - CW'(1);
    end else begin
      stk_cnt_nxt = stk_cnt_r;
    end
    // Read the entry that will be on top after this edge.
    ram_raddr = stk_cnt_nxt[AW-1:0] - AW'(1);
  end

  pbe_ram #(
    .WIDTH (8),
    .DEPTH (pbe_pkg::STACK_DEPTH)
  ) u_stack (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (stk_cnt_r[AW-1:0]),
    .wr_data (push_val),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // ---------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------
  always_comb begin
    phase_nxt    = phase_r;
    bus_nxt      = bus_r;
    dev_nxt      = dev_r;
    fn_nxt       = fn_r;
    saved_id_nxt = saved_id_r;
    ovf_nxt      = ovf_r || ovf_set;
    if (start_go) begin
      phase_nxt    = pbe_pkg::PH_ID;
      bus_nxt      = '0;
      dev_nxt      = '0;
      fn_nxt       = '0;
      saved_id_nxt = '0;
      ovf_nxt      = 1'b0;
    end else if (adv_en) begin
      fn_nxt = fn_wrap ? 3'd0 : fn_r + 3'd1;
      if (fn_wrap) begin
        dev_nxt = dev_wrap ? 5'd0 : dev_r + 5'd1;
      end
      if (stk_pop) begin
        bus_nxt = pop_val;
      end
      phase_nxt = scan_done ? pbe_pkg::PH_IDLE : pbe_pkg::PH_ID;
    end else if (rsp && (phase_r == pbe_pkg::PH_ID)) begin
      saved_id_nxt = inr_data_r;
      phase_nxt    = pbe_pkg::PH_HDR;
    end else if (rsp && (phase_r == pbe_pkg::PH_HDR)) begin
      phase_nxt = pbe_pkg::PH_BUS;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= pbe_pkg::PH_IDLE;
      bus_r      <= '0;
      dev_r      <= '0;
      fn_r       <= '0;
      saved_id_r <= '0;
      stk_cnt_r  <= '0;
      ovf_r      <= 1'b0;
      byp_r      <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      bus_r      <= bus_nxt;
      dev_r      <= dev_nxt;
      fn_r       <= fn_nxt;
      saved_id_r <= saved_id_nxt;
      stk_cnt_r  <= stk_cnt_nxt;
      ovf_r      <= ovf_nxt;
      byp_r      <= ram_we;
    end
  end

  always_ff @(posedge clk) begin
    if (ram_we) begin
      byp_data_r <= push_val;
    end
  end

  // ---------------------------------------------------------------------
  // Result generation
  // ---------------------------------------------------------------------
  function automatic pbe_pkg::result_t mk_res(pbe_pkg::res_kind_t k, logic [7:0] b,
                                              logic [4:0] d, logic [2:0] f,
                                              logic [4:0] off, logic [31:0] id,
                                              logic ov);
    pbe_pkg::result_t r;
    r.result_kind      = k;
    r.bus_number       = b;
    r.device_number    = d;
    r.function_number  = f;
    r.register_offset  = off;
    r.id_word          = id;
    r.stack_overflowed = ov;
    r.last             = 1'b0;
    return r;
  endfunction

  always_comb begin
    pbe_pkg::result_t adv_res;
    if (scan_done) begin
      adv_res = mk_res(pbe_pkg::RK_DONE, 8'd0, 5'd0, 3'd0, pbe_pkg::OFF_ID, 32'd0,
                       ovf_r || ovf_set);
    end else begin
      adv_res = mk_res(pbe_pkg::RK_REQ, bus_nxt, dev_nxt, fn_nxt, pbe_pkg::OFF_ID,
                       32'd0, 1'b0);
    end
    r0    = adv_res;
    r1    = adv_res;
    n_res = 2'd0;
    if (start_go) begin
      r0    = mk_res(pbe_pkg::RK_REQ, 8'd0, 5'd0, 3'd0, pbe_pkg::OFF_ID, 32'd0, 1'b0);
      n_res = 2'd1;
    end else if (rsp) begin
      unique case (phase_r)
        pbe_pkg::PH_ID: begin
          if (!id_absent) begin
            r0 = mk_res(pbe_pkg::RK_REQ, bus_r, dev_r, fn_r, pbe_pkg::OFF_HDR, 32'd0, 1'b0);
          end
          n_res = 2'd1;
        end
        pbe_pkg::PH_HDR: begin
          if (hdr_bridge) begin
            r0    = mk_res(pbe_pkg::RK_REQ, bus_r, dev_r, fn_r, pbe_pkg::OFF_BUS,
                           32'd0, 1'b0);
            n_res = 2'd1;
          end else begin
            // found device, then the next request or done
            r0    = mk_res(pbe_pkg::RK_FOUND, bus_r, dev_r, fn_r, pbe_pkg::OFF_ID,
                           saved_id_r, 1'b0);
            n_res = 2'd2;
          end
        end
        pbe_pkg::PH_BUS: begin
          n_res = 2'd1;
        end
        default: begin
          n_res = 2'd0;
        end
      endcase
    end
    r0.last = (n_res == 2'd1);
    r1.last = 1'b1;
  end

  // ---------------------------------------------------------------------
  // Result queue
  // ---------------------------------------------------------------------
  assign q_pop   = out_valid && out_ready;
  assign q_tail1 = q_tail_r + pbe_pkg::QAW'(1);

  always_ff @(posedge clk) begin
    if (n_res != 2'd0) begin
      q_mem_r[q_tail_r] <= r0;
    end
    if (n_res == 2'd2) begin
      q_mem_r[q_tail1] <= r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_head_r <= '0;
      q_tail_r <= '0;
      q_cnt_r  <= '0;
    end else begin
      q_tail_r <= q_tail_r + pbe_pkg::QAW'(n_res);
      if (q_pop) begin
        q_head_r <= q_head_r + pbe_pkg::QAW'(1);
      end
      q_cnt_r <= q_cnt_r + pbe_pkg::QCW'(n_res) - pbe_pkg::QCW'(q_pop);
    end
  end

  assign out_valid            = (q_cnt_r != '0);
  assign out_result_kind      = q_mem_r[q_head_r].result_kind;
  assign out_bus_number       = q_mem_r[q_head_r].bus_number;
  assign out_device_number    = q_mem_r[q_head_r].device_number;
  assign out_function_number  = q_mem_r[q_head_r].function_number;
  assign out_register_offset  = q_mem_r[q_head_r].register_offset;
  assign out_id_word          = q_mem_r[q_head_r].id_word;
  assign out_stack_overflowed = q_mem_r[q_head_r].stack_overflowed;
  assign out_last             = q_mem_r[q_head_r].last;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_stk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stk_cnt_r <= CW'(pbe_pkg::STACK_DEPTH))
    else $error("bus stack count above depth");

  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt_r <= pbe_pkg::QCW'(pbe_pkg::QDEPTH))
    else $error("result queue overrun");

  a_idle_resp: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && (inr_kind_r == pbe_pkg::IN_RESP) && (phase_r == pbe_pkg::PH_IDLE))
      |-> (n_res == 2'd0))
    else $error("response while idle produced a result");

  a_start_phase: assert property (@(posedge clk) disable iff (!rst_n)
    start_go |=> (phase_r == pbe_pkg::PH_ID) && (stk_cnt_r == '0))
    else $error("start did not open a scan");

  a_bypass: assert property (@(posedge clk) disable iff (!rst_n)
    byp_r |-> (stk_cnt_r != '0))
    else $error("stack bypass with empty stack");

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// Testbench for pci_bus_enumerator: scoreboard class with its own scan predictor,
// plus the top module that plays config space back to the block. Uses pbe_pkg.
import pbe_pkg::*;

// Scoreboard: keeps its own copy of the scan state and the bus stack, predicts
// the results each accepted transaction causes, and checks results in order.
class scan_scoreboard;
  phase_t      phase;
  int unsigned bus, dev, fn;
  logic [31:0] saved_id;
  logic [7:0]  bus_stack [STACK_DEPTH];
  int unsigned stacked;
  bit          overflowed;
  result_t     scan_results[$];
  int unsigned errors, found_seen, done_seen, overflow_done_seen;

  function new();
    phase = PH_IDLE;
    bus = 0;
    dev = 0;
    fn = 0;
    saved_id = '0;
    stacked = 0;
    overflowed = 1'b0;
    errors = 0;
    found_seen = 0;
    done_seen = 0;
    overflow_done_seen = 0;
  endfunction

  function void post(res_kind_t kind, int unsigned b, int unsigned d, int unsigned f,
                     logic [4:0] off, logic [31:0] id, bit ovf);
    result_t r;
    r.result_kind      = kind;
    r.bus_number       = b[7:0];
    r.device_number    = d[4:0];
    r.function_number  = f[2:0];
    r.register_offset  = off;
    r.id_word          = id;
    r.stack_overflowed = ovf;
    r.last             = 1'b0;
    scan_results.push_back(r);
  endfunction

  // Next function, next device or next stacked bus; done when nothing is left.
  function void move_on(bit skip_device);
    if (!skip_device && fn + 1 < FUNCS_PER_DEV) begin
      fn++;
      phase = PH_ID;
      post(RK_REQ, bus, dev, fn, OFF_ID, '0, 1'b0);
      return;
    end
    fn = 0;
    if (dev + 1 < DEVS_PER_BUS) begin
      dev++;
      phase = PH_ID;
      post(RK_REQ, bus, dev, fn, OFF_ID, '0, 1'b0);
      return;
    end
    dev = 0;
    if (stacked == 0) begin
      phase = PH_IDLE;
      post(RK_DONE, 0, 0, 0, '0, '0, overflowed);
      return;
    end
    stacked--;
    bus = bus_stack[stacked];
    phase = PH_ID;
    post(RK_REQ, bus, dev, fn, OFF_ID, '0, 1'b0);
  endfunction

  // Notes one accepted transaction; returns how many results it causes.
  function int walk_config_space(in_kind_t kind, logic [31:0] dword);
    int unsigned n_prior;
    result_t     tail;
    n_prior = scan_results.size();
    if (kind == IN_START) begin
      if (phase != PH_IDLE) return 0;
      stacked = 0;
      overflowed = 1'b0;
      bus = 0;
      dev = 0;
      fn = 0;
      saved_id = '0;
      phase = PH_ID;
      post(RK_REQ, bus, dev, fn, OFF_ID, '0, 1'b0);
    end else begin
      case (phase)
        PH_IDLE: return 0;
        PH_ID: begin
          if (dword[15:0] == VENDOR_NONE) begin
            move_on(fn == 0);
          end else begin
            saved_id = dword;
            phase = PH_HDR;
            post(RK_REQ, bus, dev, fn, OFF_HDR, '0, 1'b0);
          end
        end
        PH_HDR: begin
          if ((dword[22:16] & HDR_MASK) == HDR_BRIDGE) begin
            phase = PH_BUS;
            post(RK_REQ, bus, dev, fn, OFF_BUS, '0, 1'b0);
          end else begin
            post(RK_FOUND, bus, dev, fn, '0, saved_id, 1'b0);
            move_on(1'b0);
          end
        end
        default: begin
          if (stacked < STACK_DEPTH) begin
            bus_stack[stacked] = dword[15:8];
            stacked++;
          end else begin
            overflowed = 1'b1;
          end
          move_on(1'b0);
        end
      endcase
    end
    tail = scan_results.pop_back();
    tail.last = 1'b1;
    scan_results.push_back(tail);
    return scan_results.size() - n_prior;
  endfunction

  function void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endfunction

  function void check_scan_result(result_t got);
    result_t want;
    if (scan_results.size() == 0) begin
      $error("result with none pending: kind %0d bus %0h dev %0h fn %0h",
             got.result_kind, got.bus_number, got.device_number, got.function_number);
      errors++;
      return;
    end
    want = scan_results.pop_front();
    compare_field("result_kind", want.result_kind, got.result_kind);
    compare_field("bus_number", want.bus_number, got.bus_number);
    compare_field("device_number", want.device_number, got.device_number);
    compare_field("function_number", want.function_number, got.function_number);
    compare_field("register_offset", want.register_offset, got.register_offset);
    compare_field("id_word", want.id_word, got.id_word);
    compare_field("stack_overflowed", want.stack_overflowed, got.stack_overflowed);
    compare_field("last", want.last, got.last);
    if (want.result_kind == RK_FOUND) found_seen++;
    if (want.result_kind == RK_DONE) begin
      done_seen++;
      if (want.stack_overflowed) overflow_done_seen++;
    end
  endfunction
endclass

module tb;

  // Random scan transactions that take effect; with the directed opening and
  // the ignored ones the run sends about 850.
  localparam int SCAN_ITEMS   = 800;
  // Receiver holds off this long once, while the sender keeps offering.
  localparam int PRESSURE_AT  = 600;
  localparam int PRESSURE_LEN = 400;
  // Margin for the input register, result queue and drain; generous.
  localparam int DRAIN_CYCLES = 20;
  // About 850 transactions, up to two results each, longest gaps and stalls,
  // several times over.
  localparam int CYCLE_LIMIT  = 250_000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_kind;
  logic [31:0] in_read_data;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_result_kind;
  logic [7:0]  out_bus_number;
  logic [4:0]  out_device_number;
  logic [2:0]  out_function_number;
  logic [4:0]  out_register_offset;
  logic [31:0] out_id_word;
  logic        out_stack_overflowed;
  logic        out_last;

  pci_bus_enumerator dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_kind              (in_kind),
    .in_read_data         (in_read_data),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_result_kind      (out_result_kind),
    .out_bus_number       (out_bus_number),
    .out_device_number    (out_device_number),
    .out_function_number  (out_function_number),
    .out_register_offset  (out_register_offset),
    .out_id_word          (out_id_word),
    .out_stack_overflowed (out_stack_overflowed),
    .out_last             (out_last)
  );

  scan_scoreboard sb;

  int unsigned cycles;
  int unsigned counted;       // scan transactions that took effect
  int unsigned ignored_cnt;   // starts while busy, responses while idle
  int unsigned steady_left;   // transactions left in a no-gap stretch

  // Per-scan profile of the config space being played back.
  int unsigned fn0_pct;       // chance function 0 answers
  int unsigned fn_pct;        // chance another function answers
  int unsigned bridge_budget; // bridges allowed in this scan

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Cycle count and watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Result monitor: every accepted result goes to the scoreboard. Port values
  // are read at the edge before any update from it.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_scan_result('{result_kind:      res_kind_t'(out_result_kind),
                             bus_number:       out_bus_number,
                             device_number:    out_device_number,
                             function_number:  out_function_number,
                             register_offset:  out_register_offset,
                             id_word:          out_id_word,
                             stack_overflowed: out_stack_overflowed,
                             last:             out_last});
    end
  end

  // Result sink: mostly ready, short and occasional long stalls, ready-only
  // stretches, and one long hold-off so the result queue fills and in_ready drops.
  initial begin
    int unsigned stall;
    int unsigned burst;
    int unsigned r;
    bit          pressure_done;
    stall = 0;
    burst = 0;
    pressure_done = 1'b0;
    out_ready = 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (!pressure_done && cycles >= PRESSURE_AT) begin
        pressure_done = 1'b1;
        stall = PRESSURE_LEN;
        burst = 0;
      end else if (stall == 0 && burst == 0) begin
        r = $urandom_range(99);
        if (r < 4) burst = $urandom_range(20, 80);
        else if (r < 70) stall = 0;
        else if (r < 95) stall = $urandom_range(1, 3);
        else stall = $urandom_range(8, 20);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
        if (burst > 0) burst--;
      end
      @(posedge clk);
    end
  end

  // Gap after a transaction: mostly none or short, a few long, and stretches
  // with no gaps at all.
  function automatic int pick_gap();
    int unsigned r;
    if (steady_left > 0) begin
      steady_left--;
      return 0;
    end
    r = $urandom_range(99);
    if (r < 3) begin
      steady_left = $urandom_range(20, 60);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 20);
  endfunction

  // Offers one transaction, holds it until accepted, notes it, then idles for any picked gap.
  task automatic offer(input in_kind_t k, input logic [31:0] d);
    int n;
    int g;
    in_valid     <= 1'b1;
    in_kind      <= k;
    in_read_data <= d;
    do @(posedge clk); while (in_ready !== 1'b1);
    n = sb.walk_config_space(k, d);
    if (n == 0) ignored_cnt++;
    else counted++;
    g = pick_gap();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // Picks the next transaction from the scan state the scoreboard holds, so
  // most traffic answers the request actually pending; the rest is noise.
  function automatic void make_item(output in_kind_t k, output logic [31:0] d);
    bit         present;
    bit         bridge;
    logic [6:0] htype;
    d = $urandom;
    k = IN_RESP;
    if (sb.phase == PH_IDLE) begin
      // A stray response now and then; otherwise start the next scan.
      if ($urandom_range(99) < 10) return;
      k = IN_START;
      if ($urandom_range(99) < 70) begin
        fn0_pct = 6;
        fn_pct = 25;
        bridge_budget = $urandom_range(0, 1);
      end else begin
        fn0_pct = 20;
        fn_pct = 40;
        bridge_budget = $urandom_range(0, 3);
      end
      return;
    end
    // Noise: start while busy, or a response with arbitrary content.
    if ($urandom_range(99) < 5) begin
      if ($urandom_range(1) == 1) k = IN_START;
      return;
    end
    case (sb.phase)
      PH_ID: begin
        present = ($urandom_range(99) < (sb.fn == 0 ? fn0_pct : fn_pct));
        if (present) begin
          if (d[15:0] == VENDOR_NONE) d[0] = 1'b0;
        end else begin
          d[15:0] = VENDOR_NONE;
        end
      end
      PH_HDR: begin
        bridge = (bridge_budget > 0) && ($urandom_range(99) < 40);
        htype = 7'($urandom);
        if (bridge) htype = HDR_BRIDGE;
        else if (htype == HDR_BRIDGE) htype = '0;
        d[22:16] = htype;
        if (bridge) bridge_budget--;
      end
      default: begin
        // Bus-number dword: secondary bus in bits 15..8, rest random.
      end
    endcase
  endfunction

  initial begin
    in_kind_t    k;
    logic [31:0] d;
    sb = new();
    cycles = 0;
    counted = 0;
    ignored_cnt = 0;
    steady_left = 0;
    fn0_pct = 6;
    fn_pct = 25;
    bridge_budget = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_kind = IN_START;
    in_read_data = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed opening.
    offer(IN_RESP, 32'h1234_5678);   // response while idle: dropped
    offer(IN_START, 32'h0000_0000);  // scan begins at bus 0
    offer(IN_START, 32'hffff_ffff);  // start while busy: dropped
    offer(IN_RESP, 32'h0000_0000);   // fn 0 present, all-zero ID
    offer(IN_RESP, 32'h0081_0000);   // bridge, multifunction bit masked off
    offer(IN_RESP, 32'hffff_ffff);   // secondary bus 0xff pushed
    offer(IN_RESP, 32'hffff_ffff);   // fn 1 absent: skipped alone
    offer(IN_RESP, 32'hffff_fffe);   // fn 2 present
    offer(IN_RESP, 32'hffff_ffff);   // header type 0x7f: reported
    offer(IN_RESP, 32'h0000_ffff);   // fn 3 absent, upper half zero
    offer(IN_RESP, 32'h8086_1234);   // fn 4 present
    offer(IN_RESP, 32'h0000_0000);   // plain device: reported
    offer(IN_RESP, 32'h5a5a_ffff);   // fn 5..7 absent, last one moves to dev 1
    offer(IN_RESP, 32'ha5a5_ffff);
    offer(IN_RESP, 32'hffff_ffff);
    offer(IN_RESP, 32'habcd_ffff);   // dev 1 fn 0 absent: whole device skipped
    offer(IN_RESP, 32'h1111_2222);   // dev 2 fn 0 present
    offer(IN_RESP, 32'h0001_0000);   // bridge
    offer(IN_RESP, 32'h0000_0000);   // secondary bus 0 pushed
    counted = 0;

    // Random scans with mixed device density and up to three bridges each.
    while (counted < SCAN_ITEMS) begin
      make_item(k, d);
      offer(k, d);
    end
    in_valid <= 1'b0;

    while (sb.scan_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("scan transactions: %0d taking effect, %0d ignored, one long receiver stall",
             counted, ignored_cnt);
    $display("devices reported: %0d, scans done: %0d (%0d with stack overflow)",
             sb.found_seen, sb.done_seen, sb.overflow_done_seen);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
